// File: hdl/bba_pkg.sv
package bba_pkg;

  localparam int MAX_ORDER_DEF  = 10;
  localparam int OWNER_BITS_DEF = 16;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] owner_id;
    logic [10:0] request_size;
    logic [9:0]  entry_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] block_total;
    logic [15:0] entry_owner;
    logic [3:0]  entry_order;
  } res_t;

  // smallest order whose block holds the requested units
  function automatic logic [3:0] round_order(input logic [10:0] units);
    logic [3:0] ord;
    ord = 4'd12;
    for (int i = 11; i >= 0; i--) begin
      if ((12'(1) << i) >= {1'b0, units}) ord = 4'(i);
    end
    return ord;
  endfunction

endpackage

// File: hdl/buddy_block_allocator.sv
// read, or allocate with no fitting block: one pass around the cell ring
// allocate that fits: search pass plus rewrite pass
// one item at a time; busy is high for the whole item, result strobe lasts one cycle
// the receiver cannot stall; rst (synchronous) restores one free block of order MAX_ORDER, capped at 10
module buddy_block_allocator import bba_pkg::*; #(
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output logic       done,
  output res_t       result
);

  localparam int D  = 1 << MAX_ORDER;
  localparam int AW = MAX_ORDER;
  localparam int CW = MAX_ORDER + 1;
  localparam int KW = $clog2(MAX_ORDER + 1);
  localparam int DL = 1 << KW;
  localparam logic [3:0] ORD_CAP = (MAX_ORDER > 15) ? 4'd15 : 4'(MAX_ORDER);
  localparam logic [3:0] RST_ORD = (MAX_ORDER > 10) ? 4'd10 : 4'(MAX_ORDER);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SRCH  = 2'd2;
  localparam logic [1:0] S_SPLIT = 2'd3;

  logic [1:0]      state, state_next;
  logic [AW-1:0]   ctr;
  logic [CW-1:0]   count;
  cmd_t            req;
  logic [3:0]      want;
  logic            found;
  logic [3:0]      best_ord;
  logic [AW-1:0]   best_pos;
  logic [KW-1:0]   k;
  logic [OWNER_BITS-1:0] own_in;
  logic [31:0]     own_ext;
  logic            hit;
  logic            found_eff;
  logic [3:0]      best_eff;

  logic [3:0]            c_order [D];
  logic [OWNER_BITS-1:0] c_owner [D];
  logic [3:0]            tail_order;
  logic [OWNER_BITS-1:0] tail_owner;
  logic                  ring_shift;
  logic                  ld0;
  logic [3:0]            ld0_order;

  logic [3:0]            dly_order [DL];
  logic [OWNER_BITS-1:0] dly_owner [DL];

  logic       last;
  logic [3:0] cfg_clamp;

  assign busy     = (state != S_IDLE);
  assign last     = (ctr == {AW{1'b1}});
  assign own_ext  = {16'b0, req.owner_id};
  assign cfg_clamp = (cfg_wdata > ORD_CAP) ? ORD_CAP : cfg_wdata;

  always_comb begin
    own_in = own_ext[OWNER_BITS-1:0];
  end

  // a free entry that beats the best one so far, seen during the search pass
  assign hit = (state == S_SRCH) && (32'(ctr) < 32'(count)) && (c_owner[0] == '0) &&
               (c_order[0] >= want) && (!found || (c_order[0] < best_ord));
  assign found_eff = found || hit;
  assign best_eff  = hit ? c_order[0] : best_ord;

  // cell 0 is loaded with the single free block on reset or on a config write while idle
  assign ld0       = rst || (cfg_we && !busy);
  assign ld0_order = rst ? RST_ORD : cfg_clamp;
  assign ring_shift = busy;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [3:0]            nb_o;
    logic [OWNER_BITS-1:0] nb_w;
    if (i == D - 1) begin : g_tail
      assign nb_o = tail_order;
      assign nb_w = tail_owner;
    end else begin : g_mid
      assign nb_o = c_order[i+1];
      assign nb_w = c_owner[i+1];
    end
    bba_cell #(.OWN_W(OWNER_BITS)) u_cell (
      .clk      (clk),
      .shift    (ring_shift),
      .ld       ((i == 0) ? ld0 : 1'b0),
      .ld_order (ld0_order),
      .ld_owner ('0),
      .nb_order (nb_o),
      .nb_owner (nb_w),
      .order    (c_order[i]),
      .owner    (c_owner[i])
    );
  end

  // rewrite stream: entries before the hit pass through, the hit becomes k+1
  // pieces, later entries come out of the delay line (directly when k is zero) behind the new pieces
  logic [3:0] jdiff;
  always_comb begin
    tail_order = c_order[0];
    tail_owner = c_owner[0];
    jdiff      = 4'(ctr - best_pos);
    if (state == S_SPLIT) begin
      if (ctr < best_pos) begin
        tail_order = c_order[0];
        tail_owner = c_owner[0];
      end else if (ctr == best_pos) begin
        tail_order = best_ord - 4'(k);
        tail_owner = own_in;
      end else if (32'(ctr) <= 32'(best_pos) + 32'(k)) begin
        tail_order = best_ord - 4'(k) + jdiff - 4'd1;
        tail_owner = '0;
      end else if (k == '0) begin
        tail_order = c_order[0];
        tail_owner = c_owner[0];
      end else begin
        tail_order = dly_order[KW'(k - KW'(1))];
        tail_owner = dly_owner[KW'(k - KW'(1))];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_order[0] <= c_order[0];
    dly_owner[0] <= c_owner[0];
    for (int i = 1; i < DL; i++) begin
      dly_order[i] <= dly_order[i-1];
      dly_owner[i] <= dly_owner[i-1];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = cmd.mode ? S_READ : S_SRCH;
      S_READ:  if (last) state_next = S_IDLE;
      S_SRCH:  if (last) state_next = found_eff ? S_SPLIT : S_IDLE;
      S_SPLIT: if (last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic [31:0] room;
  logic [3:0]  gap;
  assign room = 32'(D) - 32'(count);
  assign gap  = best_eff - want;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ctr         <= '0;
      count       <= CW'(1);
      done        <= 1'b0;
      found       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we && !busy) begin
        count       <= CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          ctr   <= '0;
          found <= 1'b0;
          if (start) begin
            req  <= cmd;
            want <= round_order(cmd.request_size);
            result.status      <= ST_OK;
            result.entry_owner <= '0;
            result.entry_order <= '0;
            if (cmd.mode && (32'(cmd.entry_index) >= 32'(count)))
              result.status <= ST_RANGE;
          end
        end
        S_READ: begin
          ctr <= ctr + AW'(1);
          if ((32'(ctr) == 32'(req.entry_index)) && (result.status == ST_OK)) begin
            result.entry_owner <= 16'({32'b0, c_owner[0]});
            result.entry_order <= c_order[0];
          end
          if (last) begin
            done               <= 1'b1;
            result.block_total <= 11'(count);
          end
        end
        S_SRCH: begin
          ctr <= ctr + AW'(1);
          if (hit) begin
            found    <= 1'b1;
            best_ord <= c_order[0];
            best_pos <= ctr;
          end
          if (last) begin
            k <= (32'(gap) < room) ? KW'(gap) : KW'(room);
            if (!found_eff) begin
              done               <= 1'b1;
              result.status      <= ST_NO_FIT;
              result.block_total <= 11'(count);
            end
          end
        end
        S_SPLIT: begin
          ctr <= ctr + AW'(1);
          if (last) begin
            done               <= 1'b1;
            count              <= count + CW'(k);
            result.block_total <= 11'(count + CW'(k));
            result.entry_order <= want;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_ends_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without an item ending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(count) <= 32'(D)) && (count != '0))
    else $error("block count out of range");

  a_nofit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_NO_FIT) |-> (32'(result.block_total) == 32'(count)))
    else $error("refused allocation changed the list");

  a_split_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT && last) |=> (count >= $past(count)))
    else $error("split pass lost blocks");
`endif

endmodule

// File: hdl/bba_cell.sv
module bba_cell import bba_pkg::*; #(
  parameter int OWN_W = OWNER_BITS_DEF
) (
  input  logic             clk,
  input  logic             shift,
  input  logic             ld,
  input  logic [3:0]       ld_order,
  input  logic [OWN_W-1:0] ld_owner,
  input  logic [3:0]       nb_order,
  input  logic [OWN_W-1:0] nb_owner,
  output logic [3:0]       order,
  output logic [OWN_W-1:0] owner
);

  always_ff @(posedge clk) begin
    if (ld) begin
      order <= ld_order;
      owner <= ld_owner;
    end else if (shift) begin
      order <= nb_order;
      owner <= nb_owner;
    end
  end

endmodule
